// ===== design/assert_macros.svh =====
// Assertion macros for the decoder.
// No dependencies; the including module supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/rvdec_pkg.sv =====
// Types and constants for the RV32I instruction decoder.
// No dependencies.
`default_nettype none

package rvdec_pkg;

    localparam logic [6:0] OPC_R      = 7'h33;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_LOAD   = 7'h03;

    localparam logic [2:0] F3_ADD_SUB = 3'd0;
    localparam logic [2:0] F3_SLL     = 3'd1;
    localparam logic [2:0] F3_SRL_SRA = 3'd5;
    localparam logic [2:0] F3_SB      = 3'd0;
    localparam logic [2:0] F3_SH      = 3'd1;

    typedef enum logic [2:0] {
        FMT_UNKNOWN = 3'd0,
        FMT_R       = 3'd1,
        FMT_I       = 3'd2,
        FMT_S       = 3'd3,
        FMT_B       = 3'd4,
        FMT_J       = 3'd5,
        FMT_U       = 3'd6,
        FMT_SHIFTI  = 3'd7
    } t_format;

    typedef enum logic [5:0] {
        OP_NONE  = 6'd0,
        OP_ADD   = 6'd1,  OP_SUB   = 6'd2,  OP_SLL   = 6'd3,  OP_SLT   = 6'd4,
        OP_SLTU  = 6'd5,  OP_XOR   = 6'd6,  OP_SRL   = 6'd7,  OP_SRA   = 6'd8,
        OP_OR    = 6'd9,  OP_AND   = 6'd10, OP_JALR  = 6'd11, OP_LB    = 6'd12,
        OP_LH    = 6'd13, OP_LW    = 6'd14, OP_LBU   = 6'd15, OP_LHU   = 6'd16,
        OP_ADDI  = 6'd17, OP_SLTI  = 6'd18, OP_SLTIU = 6'd19, OP_XORI  = 6'd20,
        OP_ORI   = 6'd21, OP_ANDI  = 6'd22, OP_SB    = 6'd23, OP_SH    = 6'd24,
        OP_SW    = 6'd25, OP_BEQ   = 6'd26, OP_BNE   = 6'd27, OP_BLT   = 6'd28,
        OP_BGE   = 6'd29, OP_BLTU  = 6'd30, OP_BGEU  = 6'd31, OP_JAL   = 6'd32,
        OP_AUIPC = 6'd33, OP_LUI   = 6'd34, OP_SRLI  = 6'd35, OP_SLLI  = 6'd36,
        OP_SRAI  = 6'd37
    } t_op;

    // Opcode class, resolved in the first stage.
    typedef enum logic [3:0] {
        CLS_NONE,
        CLS_R,
        CLS_STORE,
        CLS_BRANCH,
        CLS_JAL,
        CLS_SHIFTI,
        CLS_LUI,
        CLS_AUIPC,
        CLS_JALR,
        CLS_LOAD,
        CLS_OPIMM
    } t_class;

    // Operation tables indexed by funct3.
    localparam t_op R_OPS [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                  OP_XOR, OP_SRL, OP_OR, OP_AND};
    localparam t_op LD_OPS [8] = '{OP_LB, OP_LH, OP_LW, OP_NONE,
                                   OP_LBU, OP_LHU, OP_NONE, OP_NONE};
    localparam t_op AI_OPS [8] = '{OP_ADDI, OP_NONE, OP_SLTI, OP_SLTIU,
                                   OP_XORI, OP_NONE, OP_ORI, OP_ANDI};
    localparam t_op BR_OPS [8] = '{OP_BEQ, OP_BNE, OP_NONE, OP_NONE,
                                   OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};

endpackage

`default_nettype wire

// ===== design/rv32i_instruction_decoder.sv =====
// RV32I instruction decoder: opcode class, format, operation, registers
// and immediate. Depends on rvdec_pkg and assert_macros.svh.
//
// Usage:
// - Input channel: i_valid / o_stall with i_instr_word. A request is taken
//   at a rising edge with i_valid high and o_stall low.
// - Output channel: o_valid / i_stall with the decoded fields. A request is
//   delivered at a rising edge with o_valid high and i_stall low.
// - Three register stages: opcode class, then format and operation, then
//   immediate assembly into the output register.
// - Throughput is one instruction per cycle unless i_stall holds the output;
//   each stage moves on when it is empty or the stage after it moves on.
// - When the receiver stalls, the output holds and bubbles are squeezed
//   out; o_stall rises only once all three stages hold requests.
// - Reset clears all stage valid bits; the pipeline starts empty.
`default_nettype none

module rv32i_instruction_decoder
    import rvdec_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [31:0]        i_instr_word,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_format_kind,
    output logic [5:0]              o_operation,
    output logic [4:0]              o_dest_reg,
    output logic [4:0]              o_src_reg_a,
    output logic [4:0]              o_src_reg_b,
    output logic signed [31:0]      o_imm_value
);

`include "assert_macros.svh"

    logic        r_v1, r_v2, r_v3;
    logic        adv1, adv2, adv3;

    logic [31:0] r_w1, r_w2;
    t_class      r_cls1, r_cls2, n_cls1;
    t_format     r_fmt2, n_fmt2, r_fmt3;
    t_op         r_op2, n_op2, r_op3;
    logic [31:0] n_imm3, r_imm3;
    logic [4:0]  r_rd3, r_rs1_3, r_rs2_3;

    // Handshake: each stage moves when empty or when the next one moves
    assign adv3    = !r_v3 || !i_stall;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    // Stage 1: opcode class
    logic [6:0] opc0;
    logic [2:0] f3_0;
    assign opc0 = i_instr_word[6:0];
    assign f3_0 = i_instr_word[14:12];

    always_comb begin
        unique case (opc0)
            OPC_R:      n_cls1 = CLS_R;
            OPC_STORE:  n_cls1 = CLS_STORE;
            OPC_BRANCH: n_cls1 = CLS_BRANCH;
            OPC_JAL:    n_cls1 = CLS_JAL;
            OPC_OPIMM:  n_cls1 = (f3_0 == F3_SLL || f3_0 == F3_SRL_SRA) ?
                                 CLS_SHIFTI : CLS_OPIMM;
            OPC_LUI:    n_cls1 = CLS_LUI;
            OPC_AUIPC:  n_cls1 = CLS_AUIPC;
            OPC_JALR:   n_cls1 = CLS_JALR;
            OPC_LOAD:   n_cls1 = CLS_LOAD;
            default:    n_cls1 = CLS_NONE;
        endcase
    end

    // Stage 2: format and operation
    logic [2:0] f3_1;
    logic       f7nz_1;
    assign f3_1   = r_w1[14:12];
    assign f7nz_1 = |r_w1[31:25];

    always_comb begin
        unique case (r_cls1)
            CLS_R: begin
                n_fmt2 = FMT_R;
                if (f7nz_1 && f3_1 == F3_ADD_SUB) begin
                    n_op2 = OP_SUB;
                end else if (f7nz_1 && f3_1 == F3_SRL_SRA) begin
                    n_op2 = OP_SRA;
                end else begin
                    n_op2 = R_OPS[f3_1];
                end
            end
            CLS_STORE: begin
                n_fmt2 = FMT_S;
                n_op2  = (f3_1 == F3_SB) ? OP_SB : ((f3_1 == F3_SH) ? OP_SH : OP_SW);
            end
            CLS_BRANCH: begin
                n_fmt2 = FMT_B;
                n_op2  = BR_OPS[f3_1];
            end
            CLS_JAL: begin
                n_fmt2 = FMT_J;
                n_op2  = OP_JAL;
            end
            CLS_SHIFTI: begin
                n_fmt2 = FMT_SHIFTI;
                if (f7nz_1) begin
                    n_op2 = OP_SRAI;
                end else begin
                    n_op2 = (f3_1 == F3_SRL_SRA) ? OP_SRLI : OP_SLLI;
                end
            end
            CLS_LUI: begin
                n_fmt2 = FMT_U;
                n_op2  = OP_LUI;
            end
            CLS_AUIPC: begin
                n_fmt2 = FMT_U;
                n_op2  = OP_AUIPC;
            end
            CLS_JALR: begin
                n_fmt2 = FMT_I;
                n_op2  = OP_JALR;
            end
            CLS_LOAD: begin
                n_fmt2 = FMT_I;
                n_op2  = LD_OPS[f3_1];
            end
            CLS_OPIMM: begin
                n_fmt2 = FMT_I;
                n_op2  = AI_OPS[f3_1];
            end
            default: begin
                n_fmt2 = FMT_UNKNOWN;
                n_op2  = OP_NONE;
            end
        endcase
    end

    // Stage 3: immediate assembly
    always_comb begin
        unique case (r_cls2)
            CLS_STORE:
                n_imm3 = {{20{r_w2[31]}}, r_w2[31:25], r_w2[11:7]};
            CLS_BRANCH:
                n_imm3 = {{19{r_w2[31]}}, r_w2[31], r_w2[7], r_w2[30:25],
                          r_w2[11:8], 1'b0};
            CLS_JAL:
                n_imm3 = {{11{r_w2[31]}}, r_w2[31], r_w2[19:12], r_w2[20],
                          r_w2[30:21], 1'b0};
            CLS_LUI, CLS_AUIPC:
                n_imm3 = {r_w2[31:12], 12'd0};
            CLS_JALR, CLS_LOAD, CLS_OPIMM:
                n_imm3 = {{20{r_w2[31]}}, r_w2[31:20]};
            default:
                n_imm3 = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_w1   <= i_instr_word;
            r_cls1 <= n_cls1;
        end
        if (adv2) begin
            r_w2   <= r_w1;
            r_cls2 <= r_cls1;
            r_fmt2 <= n_fmt2;
            r_op2  <= n_op2;
        end
        if (adv3) begin
            r_fmt3  <= r_fmt2;
            r_op3   <= r_op2;
            r_imm3  <= n_imm3;
            r_rd3   <= r_w2[11:7];
            r_rs1_3 <= r_w2[19:15];
            r_rs2_3 <= r_w2[24:20];
        end
    end

    assign o_valid       = r_v3;
    assign o_format_kind = r_fmt3;
    assign o_operation   = r_op3;
    assign o_dest_reg    = r_rd3;
    assign o_src_reg_a   = r_rs1_3;
    assign o_src_reg_b   = r_rs2_3;
    assign o_imm_value   = signed'(r_imm3);

    // Assertions
    `ASSERT_IMPL(a_unknown_is_blank, i_clk, i_rst_n, o_valid && o_format_kind == FMT_UNKNOWN, o_operation == OP_NONE && o_imm_value == 32'sd0)
    `ASSERT_IMPL(a_no_imm_for_reg, i_clk, i_rst_n, o_valid && (o_format_kind == FMT_R || o_format_kind == FMT_SHIFTI), o_imm_value == 32'sd0)
    `ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, r_v1 && r_v2 && r_v3 && i_stall)
    `ASSERT_NEXT(a_stage_moves_on, i_clk, i_rst_n, r_v2 && !r_v3, r_v3)

endmodule

`default_nettype wire

// ===== sim/tb_rv32i_instruction_decoder.sv =====
// Testbench for rv32i_instruction_decoder: directed and random instruction words,
// with decodes predicted on acceptance and checked in order against the output channel.
// Depends on rvdec_pkg and the decoder RTL.
`default_nettype none

module tb_rv32i_instruction_decoder;
    import rvdec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1450;

    // funct3 values not named in the package
    localparam logic [2:0] F3_WORD     = 3'd2;
    localparam logic [2:0] F3_BR_UNDEF = 3'd2;
    localparam logic [2:0] F3_LD_UNDEF = 3'd3;
    localparam logic [2:0] F3_ALL_ONES = 3'd7;

    localparam t_op ALU_BY_F3 [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                      OP_XOR, OP_SRL, OP_OR, OP_AND};
    localparam t_op LOAD_BY_F3 [8] = '{OP_LB, OP_LH, OP_LW, OP_NONE,
                                       OP_LBU, OP_LHU, OP_NONE, OP_NONE};
    localparam t_op ALUI_BY_F3 [8] = '{OP_ADDI, OP_NONE, OP_SLTI, OP_SLTIU,
                                       OP_XORI, OP_NONE, OP_ORI, OP_ANDI};
    localparam t_op BRANCH_BY_F3 [8] = '{OP_BEQ, OP_BNE, OP_NONE, OP_NONE,
                                         OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};

    localparam logic [6:0] VALID_OPCODES [9] = '{OPC_R, OPC_JALR, OPC_OPIMM, OPC_STORE,
                                                 OPC_BRANCH, OPC_JAL, OPC_LUI, OPC_AUIPC,
                                                 OPC_LOAD};

    typedef struct packed {
        t_format     fmt;
        t_op         op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
    } decoded_t;

    typedef struct {
        logic [31:0] word;
        bit          hold;      // wait for the pipeline to drain before sending
    } request_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_instr_word = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_format_kind;
    logic [5:0]  o_operation;
    logic [4:0]  o_dest_reg;
    logic [4:0]  o_src_reg_a;
    logic [4:0]  o_src_reg_b;
    logic signed [31:0] o_imm_value;

    request_t pending_q[$];
    decoded_t decoded_q[$];

    int  err_cnt = 0;
    int  sent_cnt = 0;
    int  recv_cnt = 0;
    int  stall_cycles = 0;
    int  gap_left = 0;
    int  burst_left = 0;
    int  stall_mode = 0;
    int  mode_left = 0;
    int  cyc = 0;
    bit  ops_seen [64];
    bit  fmts_seen [8];

    rv32i_instruction_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_instr_word  (i_instr_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_format_kind (o_format_kind),
        .o_operation   (o_operation),
        .o_dest_reg    (o_dest_reg),
        .o_src_reg_a   (o_src_reg_a),
        .o_src_reg_b   (o_src_reg_b),
        .o_imm_value   (o_imm_value)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic decoded_t decode_instr(input logic [31:0] w);
        decoded_t   d;
        logic [2:0] f3;
        logic       f7_set;
        f3 = w[14:12];
        f7_set = |w[31:25];
        d.fmt = FMT_UNKNOWN;
        d.op  = OP_NONE;
        d.rd  = w[11:7];
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.imm = '0;
        case (w[6:0])
            OPC_R: begin
                d.fmt = FMT_R;
                d.op = ALU_BY_F3[f3];
                if (f7_set && f3 == F3_ADD_SUB) d.op = OP_SUB;
                if (f7_set && f3 == F3_SRL_SRA) d.op = OP_SRA;
            end
            OPC_STORE: begin
                d.fmt = FMT_S;
                d.op = (f3 == F3_SB) ? OP_SB : (f3 == F3_SH) ? OP_SH : OP_SW;
                d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            end
            OPC_BRANCH: begin
                d.fmt = FMT_B;
                d.op = BRANCH_BY_F3[f3];
                d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
            OPC_JAL: begin
                d.fmt = FMT_J;
                d.op = OP_JAL;
                d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OPC_LUI, OPC_AUIPC: begin
                d.fmt = FMT_U;
                d.op = (w[6:0] == OPC_AUIPC) ? OP_AUIPC : OP_LUI;
                d.imm = {w[31:12], 12'b0};
            end
            OPC_OPIMM: begin
                if (f3 == F3_SLL || f3 == F3_SRL_SRA) begin
                    // shamt travels in rs2, no immediate
                    d.fmt = FMT_SHIFTI;
                    d.op = f7_set ? OP_SRAI : (f3 == F3_SRL_SRA) ? OP_SRLI : OP_SLLI;
                end else begin
                    d.fmt = FMT_I;
                    d.op = ALUI_BY_F3[f3];
                    d.imm = {{20{w[31]}}, w[31:20]};
                end
            end
            OPC_JALR, OPC_LOAD: begin
                d.fmt = FMT_I;
                d.op = (w[6:0] == OPC_JALR) ? OP_JALR : LOAD_BY_F3[f3];
                d.imm = {{20{w[31]}}, w[31:20]};
            end
            default: ;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] mk_word(input logic [6:0] opc, input logic [2:0] f3,
                                            input logic [6:0] f7, input logic [4:0] rd,
                                            input logic [4:0] rs1, input logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    task automatic add_req(input logic [31:0] w, input bit hold);
        request_t r;
        r.word = w;
        r.hold = hold;
        pending_q.push_back(r);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : drv_blk
        request_t nxt;
        decoded_t d;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                d = decode_instr(i_instr_word);
                decoded_q.push_back(d);
                ops_seen[d.op] = 1'b1;
                fmts_seen[d.fmt] = 1'b1;
                sent_cnt++;
            end
            if (i_valid && o_stall) begin
                // request held until taken
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (pending_q[0].hold && decoded_q.size() != 0) begin
                i_valid <= 1'b0;
            end else begin
                nxt = pending_q.pop_front();
                i_instr_word <= nxt.word;
                i_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 16);
                end
            end
        end
    end

    // Receiver: checks each delivered request, then picks the next stall value.
    always @(posedge i_clk) begin : mon_blk
        decoded_t exp_d;
        decoded_t got_d;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            cyc++;
            if (i_stall) stall_cycles++;
            if (o_valid && !i_stall) begin
                got_d.fmt = t_format'(o_format_kind);
                got_d.op  = t_op'(o_operation);
                got_d.rd  = o_dest_reg;
                got_d.rs1 = o_src_reg_a;
                got_d.rs2 = o_src_reg_b;
                got_d.imm = o_imm_value;
                if (decoded_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("unexpected result at cycle %0d: fmt=%0d op=%0d",
                                 cyc, got_d.fmt, got_d.op);
                    err_cnt++;
                end else begin
                    exp_d = decoded_q.pop_front();
                    if (got_d.fmt !== exp_d.fmt || got_d.op !== exp_d.op ||
                        got_d.rd !== exp_d.rd || got_d.rs1 !== exp_d.rs1 ||
                        got_d.rs2 !== exp_d.rs2 || got_d.imm !== exp_d.imm) begin
                        if (err_cnt < 10) begin
                            $display("mismatch on result %0d:", recv_cnt);
                            $display("  exp fmt=%0d op=%0d rd=%0d rs1=%0d rs2=%0d imm=%h",
                                     exp_d.fmt, exp_d.op, exp_d.rd, exp_d.rs1,
                                     exp_d.rs2, exp_d.imm);
                            $display("  got fmt=%0d op=%0d rd=%0d rs1=%0d rs2=%0d imm=%h",
                                     got_d.fmt, got_d.op, got_d.rd, got_d.rs1,
                                     got_d.rs2, got_d.imm);
                        end
                        err_cnt++;
                    end
                end
                recv_cnt++;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 1) != 0);
                2: i_stall <= ($urandom_range(0, 7) != 0);
                default: i_stall <= cyc[1];
            endcase
        end
    end

    initial begin : main_blk
        logic [31:0] w;
        int          n_ops;
        int          n_fmts;
        int          sel;

        // directed: field extremes, every format and the odd corners of decoding
        add_req(32'h0000_0000, 1'b0);
        add_req(32'hFFFF_FFFF, 1'b0);
        add_req(mk_word(OPC_R, F3_ADD_SUB, 7'h00, 5'd1, 5'd2, 5'd3), 1'b0);
        add_req(mk_word(OPC_R, F3_ADD_SUB, 7'h01, 5'd31, 5'd31, 5'd31), 1'b0);
        add_req(mk_word(OPC_R, F3_SRL_SRA, 7'h20, 5'd4, 5'd5, 5'd6), 1'b0);
        add_req(mk_word(OPC_R, F3_SRL_SRA, 7'h00, 5'd7, 5'd8, 5'd9), 1'b0);
        add_req(mk_word(OPC_R, F3_ALL_ONES, 7'h7F, 5'd0, 5'd0, 5'd0), 1'b0);
        add_req(mk_word(OPC_OPIMM, F3_SLL, 7'h00, 5'd5, 5'd6, 5'd31), 1'b0);
        add_req(mk_word(OPC_OPIMM, F3_SRL_SRA, 7'h00, 5'd10, 5'd11, 5'd1), 1'b0);
        // nonzero funct7 gives srai even with the left-shift funct3
        add_req(mk_word(OPC_OPIMM, F3_SLL, 7'h40, 5'd12, 5'd13, 5'd17), 1'b0);
        add_req(mk_word(OPC_OPIMM, F3_SRL_SRA, 7'h20, 5'd14, 5'd15, 5'd0), 1'b0);
        add_req(mk_word(OPC_OPIMM, F3_ADD_SUB, 7'h40, 5'd3, 5'd4, 5'd0), 1'b0);
        add_req(mk_word(OPC_OPIMM, F3_ALL_ONES, 7'h3F, 5'd3, 5'd4, 5'd31), 1'b0);
        add_req(mk_word(OPC_LOAD, F3_LD_UNDEF, 7'h55, 5'd9, 5'd9, 5'd9), 1'b0);
        add_req(mk_word(OPC_LOAD, F3_WORD, 7'h2A, 5'd1, 5'd30, 5'd21), 1'b0);
        add_req(mk_word(OPC_JALR, F3_ALL_ONES, 7'h7F, 5'd1, 5'd1, 5'd31), 1'b0);
        add_req(mk_word(OPC_STORE, F3_SB, 7'h40, 5'd0, 5'd2, 5'd3), 1'b0);
        add_req(mk_word(OPC_STORE, F3_SH, 7'h3F, 5'd31, 5'd2, 5'd3), 1'b0);
        add_req(mk_word(OPC_STORE, F3_ALL_ONES, 7'h11, 5'd17, 5'd19, 5'd23), 1'b0);
        add_req(mk_word(OPC_BRANCH, F3_BR_UNDEF, 7'h33, 5'd6, 5'd7, 5'd8), 1'b0);
        add_req(mk_word(OPC_BRANCH, F3_ADD_SUB, 7'h40, 5'd1, 5'd0, 5'd0), 1'b0);
        add_req(mk_word(OPC_BRANCH, F3_ALL_ONES, 7'h3F, 5'd30, 5'd31, 5'd31), 1'b0);
        add_req({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL}, 1'b0);
        add_req({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, OPC_JAL}, 1'b0);
        add_req({20'hFFFFF, 5'd31, OPC_LUI}, 1'b0);
        add_req({20'h00001, 5'd0, OPC_AUIPC}, 1'b0);
        add_req(mk_word(OPC_R ^ 7'h01, F3_ADD_SUB, 7'h00, 5'd1, 5'd2, 5'd3), 1'b0);

        // random: mostly valid opcodes with random fields, some raw noise
        for (int i = 0; i < N_RANDOM; i++) begin
            w = $urandom;
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
                w[6:0] = VALID_OPCODES[$urandom_range(0, 8)];
                sel = $urandom_range(0, 9);
                if (sel < 4) w[31:25] = 7'h00;
                else if (sel < 6) w[31:25] = 7'h20;
            end else if (sel < 92) begin
                // near miss on the opcode
                w[6:0] = VALID_OPCODES[$urandom_range(0, 8)] ^ (7'h01 << $urandom_range(0, 6));
            end
            add_req(w, i == 0 || i == N_RANDOM / 2);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || i_valid) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        n_ops = 0;
        n_fmts = 0;
        for (int k = 0; k < 64; k++) if (ops_seen[k]) n_ops++;
        for (int k = 0; k < 8; k++) if (fmts_seen[k]) n_fmts++;
        $display("%0d instruction words decoded and checked, %0d of 38 operation codes",
                 recv_cnt, n_ops);
        $display("and %0d of 8 format classes seen; receiver stalled on %0d of %0d cycles",
                 n_fmts, stall_cycles, cyc);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d sent, %0d received", sent_cnt, recv_cnt);
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
